// ===== design/mta_pkg.sv =====
// shared types and constants of the mip texel address generator
package mta_pkg;

	localparam int unsigned MAX_LEVELS = 15;
	localparam int unsigned MAX_DIM    = 16384;

	localparam int unsigned DIM_W   = 15;
	localparam int unsigned DEP_W   = 12;
	localparam int unsigned LVL_W   = 4;
	localparam int unsigned CH_W    = 3;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned ZC_W    = 11;
	localparam int unsigned SLICE_W = 11;
	localparam int unsigned ADDR_W  = 48;
	localparam int unsigned MB_W    = 18;
	localparam int unsigned RC_W    = 17;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDAT_W  = 15;

	localparam logic [CIDX_W-1:0] REG_WIDTH    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd1;
	localparam logic [CIDX_W-1:0] REG_DEPTH    = 3'd2;
	localparam logic [CIDX_W-1:0] REG_LEVELS   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_CHANNELS = 3'd4;
	localparam logic [CIDX_W-1:0] REG_CLAMP    = 3'd5;
	localparam logic [CIDX_W-1:0] REG_MODE     = 3'd6;

	localparam logic [1:0] MODE_1D = 2'd0;
	localparam logic [1:0] MODE_2D = 2'd1;
	localparam logic [1:0] MODE_3D = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DEP_W-1:0] depth;
		logic [LVL_W-1:0] levels;
		logic [CH_W-1:0]  channels;
		logic [2:0]       clamp_mask;
		logic [1:0]       mode;
	} cfg_t;

endpackage

// ===== design/mta_cfg.sv =====
// configuration registers with base size and level count fitting
module mta_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mta_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [mta_pkg::CDAT_W-1:0]     cfg_data,
	output mta_pkg::cfg_t                  cfg
);

	localparam logic [16:0] DIM_MAX_C = 17'(mta_pkg::MAX_DIM);
	localparam logic [4:0]  LVL_MAX_C = 5'(mta_pkg::MAX_LEVELS);

	logic [mta_pkg::DIM_W-1:0] width_q;
	logic [mta_pkg::DIM_W-1:0] height_q;
	logic [mta_pkg::DEP_W-1:0] depth_q;
	logic [mta_pkg::LVL_W-1:0] levels_q;
	logic [mta_pkg::CH_W-1:0]  channels_q;
	logic [2:0]                clamp_q;
	logic [1:0]                mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= 15'd1;
			height_q   <= 15'd1;
			depth_q    <= 12'd1;
			levels_q   <= 4'd1;
			channels_q <= 3'd4;
			clamp_q    <= 3'd0;
			mode_q     <= mta_pkg::MODE_2D;
		end else if (cfg_valid) begin
			case (cfg_index)
				mta_pkg::REG_WIDTH:    width_q    <= cfg_data[14:0];
				mta_pkg::REG_HEIGHT:   height_q   <= cfg_data[14:0];
				mta_pkg::REG_DEPTH:    depth_q    <= cfg_data[11:0];
				mta_pkg::REG_LEVELS:   levels_q   <= cfg_data[3:0];
				mta_pkg::REG_CHANNELS: channels_q <= cfg_data[2:0];
				mta_pkg::REG_CLAMP:    clamp_q    <= cfg_data[2:0];
				mta_pkg::REG_MODE:     mode_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [16:0] fit_dim(input logic [16:0] d);
		logic [16:0] r;
		if (d == 17'd0)
			r = 17'd1;
		else if (d > DIM_MAX_C)
			r = DIM_MAX_C;
		else
			r = d;
		return r;
	endfunction

	logic [16:0] w_fit, h_fit, d_fit;
	logic [4:0]  nl_fit;

	always_comb begin
		w_fit = fit_dim({2'b0, width_q});
		h_fit = fit_dim({2'b0, height_q});
		d_fit = fit_dim({5'b0, depth_q});
		if (levels_q == 4'd0)
			nl_fit = 5'd1;
		else if ({1'b0, levels_q} > LVL_MAX_C)
			nl_fit = LVL_MAX_C;
		else
			nl_fit = {1'b0, levels_q};
	end

	assign cfg.width      = w_fit[14:0];
	assign cfg.height     = h_fit[14:0];
	assign cfg.depth      = d_fit[11:0];
	assign cfg.levels     = nl_fit[3:0];
	assign cfg.channels   = channels_q;
	assign cfg.clamp_mask = clamp_q;
	assign cfg.mode       = mode_q;

endmodule

// ===== design/mta_remap.sv =====
// one axis clamp or single wrap into the level size, or a bypass of both
module mta_remap (
	input  logic signed [mta_pkg::COORD_W-1:0] coord,
	input  logic [mta_pkg::DIM_W-1:0]          size,
	input  logic                               clamp,
	input  logic                               bypass,
	output logic signed [mta_pkg::RC_W-1:0]    coord_out
);

	logic signed [17:0] c;
	logic signed [17:0] s;
	logic signed [17:0] r;

	always_comb begin
		c = 18'(coord);
		s = $signed({3'b0, size});
		r = c;
		if (!bypass) begin
			if (clamp) begin
				if (c > s - 18'sd1)
					r = s - 18'sd1;
				else if (c < 18'sd0)
					r = 18'sd0;
			end else if (c < 18'sd0) begin
				r = c + s;
			end else if (c >= s) begin
				r = c - s;
			end
		end
		coord_out = r[16:0];
	end

endmodule

// ===== design/mta_mac.sv =====
// shared multiply-add unit, result modulo 2^48
module mta_mac (
	input  logic [mta_pkg::ADDR_W-1:0] a,
	input  logic [mta_pkg::MB_W-1:0]   b,
	input  logic [mta_pkg::ADDR_W-1:0] c,
	output logic [mta_pkg::ADDR_W-1:0] r
);

	logic [mta_pkg::ADDR_W+mta_pkg::MB_W-1:0] prod;

	always_comb begin
		prod = {{mta_pkg::MB_W{1'b0}}, a} * {{mta_pkg::ADDR_W{1'b0}}, b};
		r    = prod[mta_pkg::ADDR_W-1:0] + c;
	end

endmodule

// ===== design/mip_texel_address_generator.sv =====
// mip texel address generator top level with sequencer
//
// channel  | handshake                      | payload
// s_axis   | s_axis_tvalid / s_axis_tready  | s_axis_tdata[63:0] coordinates, slice, level
// m_axis   | m_axis_tvalid / m_axis_tready  | m_axis_tdata[47:0] element address
// cfg      | cfg_valid / cfg_ready          | cfg_index[2:0], cfg_data[14:0]
//
// one multiply-add unit serves the mip size chain, slice base, row, layer and column terms
// s_axis_tready is high only while the sequencer is idle
// a finished address waits in the output register while the next item is taken
// a stalled output holds the sequencer in its last step
// reset clears the sequencer and output valid; cfg writes are always taken
module mip_texel_address_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// coord_x[15:0], coord_y[31:16], coord_z[42:32], slice_index[53:43], level[57:54]
	input  logic [63:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// element_address[47:0]
	output logic [47:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int unsigned AW = mta_pkg::ADDR_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LVL_W = 4'd1;
	localparam logic [3:0] ST_LVL_H = 4'd2;
	localparam logic [3:0] ST_LVL_D = 4'd3;
	localparam logic [3:0] ST_RMAP  = 4'd4;
	localparam logic [3:0] ST_BASE  = 4'd5;
	localparam logic [3:0] ST_ROW_W = 4'd6;
	localparam logic [3:0] ST_ROW_Y = 4'd7;
	localparam logic [3:0] ST_LAY_H = 4'd8;
	localparam logic [3:0] ST_LAY_Z = 4'd9;
	localparam logic [3:0] ST_COL   = 4'd10;

	mta_pkg::cfg_t cfg;

	logic [3:0]                      state_q;
	logic [mta_pkg::LVL_W-1:0]       i_q, nl_q, lvl_q;
	logic [mta_pkg::DIM_W-1:0]       wr_q, hr_q, w_sel_q, h_sel_q;
	logic [mta_pkg::DEP_W-1:0]       dr_q;
	logic [AW-1:0]                   tmp_q, ssize_q, off_q, addr_q;
	logic signed [mta_pkg::COORD_W-1:0] x_q, y_q;
	logic [mta_pkg::ZC_W-1:0]        z_q;
	logic [mta_pkg::SLICE_W-1:0]     slice_q;
	logic signed [mta_pkg::RC_W-1:0] xr_q, yr_q;
	logic                            out_valid_q;
	logic [AW-1:0]                   out_data_q;

	logic [AW-1:0]                   mac_a, mac_c, mac_r;
	logic [mta_pkg::MB_W-1:0]        mac_b;
	logic signed [mta_pkg::RC_W-1:0] xr_n, yr_n;
	logic [mta_pkg::DIM_W-1:0]       w_fit1, h_fit1;
	logic [mta_pkg::DEP_W-1:0]       d_fit1;
	logic [mta_pkg::LVL_W-1:0]       in_level, nl_m1;
	logic                            is_3d, accept, out_free;

	mta_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mta_mac u_mac (
		.a (mac_a),
		.b (mac_b),
		.c (mac_c),
		.r (mac_r)
	);

	mta_remap u_remap_x (
		.coord     (x_q),
		.size      (w_sel_q),
		.clamp     (cfg.clamp_mask[0]),
		.bypass    (is_3d),
		.coord_out (xr_n)
	);

	mta_remap u_remap_y (
		.coord     (y_q),
		.size      (h_sel_q),
		.clamp     (cfg.clamp_mask[1]),
		.bypass    (is_3d),
		.coord_out (yr_n)
	);

	assign is_3d         = (cfg.mode != mta_pkg::MODE_1D) && (cfg.mode != mta_pkg::MODE_2D);
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign in_level      = s_axis_tdata[57:54];
	assign nl_m1         = cfg.levels - 4'd1;

	// level size is the shifted base, never below one
	assign w_fit1 = (wr_q == '0) ? 15'd1 : wr_q;
	assign h_fit1 = (hr_q == '0) ? 15'd1 : hr_q;
	assign d_fit1 = (dr_q == '0) ? 12'd1 : dr_q;

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		case (state_q)
			ST_LVL_W: begin
				mac_a = {45'b0, cfg.channels};
				mac_b = {3'b0, w_fit1};
			end
			ST_LVL_H: begin
				mac_a = tmp_q;
				mac_b = {3'b0, h_fit1};
			end
			ST_LVL_D: begin
				mac_a = tmp_q;
				mac_b = {6'b0, d_fit1};
				mac_c = ssize_q;
			end
			ST_BASE: begin
				mac_a = ssize_q;
				mac_b = {7'b0, slice_q};
				mac_c = off_q;
			end
			ST_ROW_W: begin
				mac_a = {45'b0, cfg.channels};
				mac_b = {3'b0, w_sel_q};
			end
			ST_ROW_Y: begin
				mac_a = {{(AW-mta_pkg::RC_W){yr_q[16]}}, yr_q};
				mac_b = tmp_q[17:0];
				mac_c = addr_q;
			end
			ST_LAY_H: begin
				mac_a = tmp_q;
				mac_b = {3'b0, h_sel_q};
			end
			ST_LAY_Z: begin
				mac_a = tmp_q;
				mac_b = {7'b0, z_q};
				mac_c = addr_q;
			end
			ST_COL: begin
				mac_a = {{(AW-mta_pkg::RC_W){xr_q[16]}}, xr_q};
				mac_b = {15'b0, cfg.channels};
				mac_c = addr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			i_q         <= '0;
		end else begin
			if (state_q == ST_COL && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q     <= '0;
						state_q <= ST_LVL_W;
					end
				end
				ST_LVL_W: state_q <= ST_LVL_H;
				ST_LVL_H: state_q <= ST_LVL_D;
				ST_LVL_D: begin
					if (i_q == nl_q - 4'd1) begin
						state_q <= ST_RMAP;
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= ST_LVL_W;
					end
				end
				ST_RMAP: state_q <= ST_BASE;
				ST_BASE: state_q <= (cfg.mode == mta_pkg::MODE_1D) ? ST_COL : ST_ROW_W;
				ST_ROW_W: state_q <= ST_ROW_Y;
				ST_ROW_Y: state_q <= (cfg.mode == mta_pkg::MODE_2D) ? ST_COL : ST_LAY_H;
				ST_LAY_H: state_q <= ST_LAY_Z;
				ST_LAY_Z: state_q <= ST_COL;
				ST_COL: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q     <= s_axis_tdata[15:0];
					y_q     <= s_axis_tdata[31:16];
					z_q     <= s_axis_tdata[42:32];
					slice_q <= s_axis_tdata[53:43];
					nl_q    <= cfg.levels;
					lvl_q   <= (in_level > nl_m1) ? nl_m1 : in_level;
					wr_q    <= cfg.width;
					hr_q    <= cfg.height;
					dr_q    <= cfg.depth;
					ssize_q <= '0;
					off_q   <= '0;
				end
			end
			ST_LVL_W: begin
				tmp_q <= mac_r;
				if (i_q == lvl_q) begin
					w_sel_q <= w_fit1;
					h_sel_q <= h_fit1;
				end
			end
			ST_LVL_H: tmp_q <= mac_r;
			ST_LVL_D: begin
				ssize_q <= mac_r;
				if (i_q == lvl_q)
					off_q <= ssize_q;
				wr_q <= wr_q >> 1;
				hr_q <= hr_q >> 1;
				dr_q <= dr_q >> 1;
			end
			ST_RMAP: begin
				xr_q <= xr_n;
				yr_q <= yr_n;
			end
			ST_BASE:  addr_q <= mac_r;
			ST_ROW_W: tmp_q <= mac_r;
			ST_ROW_Y: addr_q <= mac_r;
			ST_LAY_H: tmp_q <= mac_r;
			ST_LAY_Z: addr_q <= mac_r;
			ST_COL: begin
				if (out_free)
					out_data_q <= mac_r;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_out_from_col: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_COL))
		else $error("output valid rose outside the column step");

	a_level_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LVL_W || state_q == ST_LVL_H || state_q == ST_LVL_D) |-> (i_q < nl_q))
		else $error("level index ran past the level count");

	a_level_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (lvl_q < nl_q))
		else $error("selected level not below the level count");

	a_col_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COL && m_axis_tvalid && !m_axis_tready) |=> (state_q == ST_COL))
		else $error("sequencer left the column step while the output was full");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_LVL_W && i_q == '0))
		else $error("accepted item did not start the level sweep");
`endif

endmodule

// ===== bench/tb.sv =====
// testbench of the mip texel address generator: directed and random items checked by a scoreboard
`timescale 1ns / 100ps

module tb;

	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned PHASES = 16;
	localparam int unsigned PHASE_ITEMS = 52;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [mta_pkg::COORD_W-1:0] x;
		logic [mta_pkg::COORD_W-1:0] y;
		logic [mta_pkg::ZC_W-1:0]    z;
		logic [mta_pkg::SLICE_W-1:0] slice;
		logic [mta_pkg::LVL_W-1:0]   lvl;
	} texel_req_t;

	class address_scoreboard;
		mta_pkg::cfg_t regs;
		logic [mta_pkg::ADDR_W-1:0] expected_addrs[$];
		int unsigned errors;

		function new();
			regs.width = 15'd1;
			regs.height = 15'd1;
			regs.depth = 12'd1;
			regs.levels = 4'd1;
			regs.channels = 3'd4;
			regs.clamp_mask = 3'd0;
			regs.mode = mta_pkg::MODE_2D;
			errors = 0;
		endfunction

		function void write_reg(logic [mta_pkg::CIDX_W-1:0] idx,
				logic [mta_pkg::CDAT_W-1:0] data);
			case (idx)
				mta_pkg::REG_WIDTH: regs.width = data;
				mta_pkg::REG_HEIGHT: regs.height = data;
				mta_pkg::REG_DEPTH: regs.depth = data[mta_pkg::DEP_W-1:0];
				mta_pkg::REG_LEVELS: regs.levels = data[mta_pkg::LVL_W-1:0];
				mta_pkg::REG_CHANNELS: regs.channels = data[mta_pkg::CH_W-1:0];
				mta_pkg::REG_CLAMP: regs.clamp_mask = data[2:0];
				mta_pkg::REG_MODE: regs.mode = data[1:0];
				default: ;
			endcase
		endfunction

		function longint unsigned level_dim(longint unsigned base, int unsigned l);
			longint unsigned b;
			b = base;
			if (b == 0)
				b = 1;
			if (b > mta_pkg::MAX_DIM)
				b = mta_pkg::MAX_DIM;
			b = b >> l;
			return (b == 0) ? 1 : b;
		endfunction

		function int unsigned clamped_level(logic [mta_pkg::LVL_W-1:0] lvl);
			int unsigned nl;
			nl = regs.levels;
			if (nl == 0)
				nl = 1;
			if (nl > mta_pkg::MAX_LEVELS)
				nl = mta_pkg::MAX_LEVELS;
			return (lvl > nl - 1) ? nl - 1 : lvl;
		endfunction

		function longint remap_axis(longint c, longint unsigned size, bit clamp);
			longint s;
			longint r;
			s = longint'(size);
			r = c;
			if (clamp) begin
				if (r > s - 1)
					r = s - 1;
				if (r < 0)
					r = 0;
			end else if (r < 0) begin
				r = r + s;
			end else if (r >= s) begin
				r = r - s;
			end
			return r;
		endfunction

		function logic [mta_pkg::ADDR_W-1:0] texel_address(texel_req_t r);
			longint unsigned ch, w, h, slice_sum, offset, sz, addr;
			longint x, y;
			int unsigned nl, lvl, i;
			ch = regs.channels;
			nl = regs.levels;
			if (nl == 0)
				nl = 1;
			if (nl > mta_pkg::MAX_LEVELS)
				nl = mta_pkg::MAX_LEVELS;
			lvl = clamped_level(r.lvl);
			slice_sum = 0;
			offset = 0;
			for (i = 0; i < nl; i++) begin
				sz = ch * level_dim(regs.width, i) * level_dim(regs.height, i)
					* level_dim(regs.depth, i);
				if (i == lvl)
					offset = slice_sum;
				slice_sum = slice_sum + sz;
			end
			w = level_dim(regs.width, lvl);
			h = level_dim(regs.height, lvl);
			x = longint'($signed(r.x));
			y = longint'($signed(r.y));
			addr = slice_sum * longint'(r.slice) + offset;
			if (regs.mode == mta_pkg::MODE_1D) begin
				x = remap_axis(x, w, regs.clamp_mask[0]);
				addr = addr + ch * longint'(unsigned'(x));
			end else if (regs.mode == mta_pkg::MODE_2D) begin
				x = remap_axis(x, w, regs.clamp_mask[0]);
				y = remap_axis(y, h, regs.clamp_mask[1]);
				addr = addr + ch * w * longint'(unsigned'(y)) + ch * longint'(unsigned'(x));
			end else begin
				addr = addr + ch * w * h * longint'(r.z) + ch * w * longint'(unsigned'(y))
					+ ch * longint'(unsigned'(x));
			end
			return addr[mta_pkg::ADDR_W-1:0];
		endfunction

		function void note(texel_req_t r);
			expected_addrs.push_back(texel_address(r));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [mta_pkg::ADDR_W-1:0] got);
			logic [mta_pkg::ADDR_W-1:0] exp_addr;
			if (expected_addrs.size() == 0) begin
				report($sformatf("unexpected item, element_address %h", got));
			end else begin
				exp_addr = expected_addrs.pop_front();
				if (got !== exp_addr)
					report($sformatf("element_address got %h expected %h", got, exp_addr));
			end
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         s_axis_tvalid;
	logic                         s_axis_tready;
	logic [63:0]                  s_axis_tdata;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready;
	logic [mta_pkg::ADDR_W-1:0]   m_axis_tdata;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [mta_pkg::CIDX_W-1:0]   cfg_index;
	logic [mta_pkg::CDAT_W-1:0]   cfg_data;

	address_scoreboard sb;
	bit steady;
	int unsigned quiet_cycles = 0;

	mip_texel_address_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic texel_req_t mk(int x, int y, int z, int slice, int lvl);
		texel_req_t r;
		r.x = 16'(x);
		r.y = 16'(y);
		r.z = 11'(z);
		r.slice = 11'(slice);
		r.lvl = 4'(lvl);
		return r;
	endfunction

	function automatic logic [15:0] pick_coord(longint unsigned size);
		int s;
		int c;
		s = int'(size);
		case ($urandom_range(0, 9))
			0, 1, 2: c = int'($urandom_range(0, s - 1));
			3, 4: c = -int'($urandom_range(1, s));
			5, 6: c = s + int'($urandom_range(0, s - 1));
			7: c = ($urandom_range(0, 1) != 0) ? -s - 1 : 2 * s;
			default: c = int'($urandom);
		endcase
		return 16'(c);
	endfunction

	function automatic logic [mta_pkg::CDAT_W-1:0] pick_base(int unsigned top,
			int unsigned high);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return mta_pkg::CDAT_W'(high);
			2: return mta_pkg::CDAT_W'(top);
			3: return mta_pkg::CDAT_W'($urandom_range(1, top));
			default: return mta_pkg::CDAT_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic texel_req_t random_req();
		texel_req_t r;
		int unsigned cl;
		longint unsigned d;
		r.lvl = 4'($urandom_range(0, 15));
		cl = sb.clamped_level(r.lvl);
		d = sb.level_dim(sb.regs.depth, cl);
		r.x = pick_coord(sb.level_dim(sb.regs.width, cl));
		r.y = pick_coord(sb.level_dim(sb.regs.height, cl));
		if ($urandom_range(0, 1) != 0)
			r.z = 11'($urandom_range(0, (d > 2048) ? 2047 : int'(d) - 1));
		else
			r.z = 11'($urandom);
		if ($urandom_range(0, 3) == 0)
			r.slice = 11'($urandom_range(0, 3));
		else
			r.slice = 11'($urandom);
		return r;
	endfunction

	task cfg_write(logic [mta_pkg::CIDX_W-1:0] idx, logic [mta_pkg::CDAT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task send_item(texel_req_t r);
		if (!steady) begin
			while ($urandom_range(0, 99) < 18) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, r.lvl, r.slice, r.z, r.y, r.x};
		do @(posedge clk); while (!s_axis_tready);
		sb.note(r);
	endtask

	task drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.expected_addrs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task random_setting();
		cfg_write(mta_pkg::REG_WIDTH, pick_base(32767, mta_pkg::MAX_DIM));
		cfg_write(mta_pkg::REG_HEIGHT, pick_base(32767, mta_pkg::MAX_DIM));
		cfg_write(mta_pkg::REG_DEPTH, pick_base(4095, 2048));
		cfg_write(mta_pkg::REG_LEVELS, mta_pkg::CDAT_W'($urandom_range(0, 15)));
		if ($urandom_range(0, 3) == 0)
			cfg_write(mta_pkg::REG_CHANNELS, mta_pkg::CDAT_W'($urandom_range(0, 7)));
		else
			cfg_write(mta_pkg::REG_CHANNELS, mta_pkg::CDAT_W'($urandom_range(1, 4)));
		cfg_write(mta_pkg::REG_CLAMP, mta_pkg::CDAT_W'($urandom_range(0, 7)));
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'($urandom_range(0, 3)));
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
		end
	end

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = mta_pkg::REG_WIDTH;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting
		send_item(mk(0, 0, 0, 0, 0));
		send_item(mk(-1, 1, 5, 3, 15));
		drain();

		// oversized and zero bases, top level count, odd channel count
		cfg_write(mta_pkg::REG_WIDTH, 15'd32767);
		cfg_write(mta_pkg::REG_HEIGHT, 15'd0);
		cfg_write(mta_pkg::REG_DEPTH, 15'd4095);
		cfg_write(mta_pkg::REG_LEVELS, 15'd15);
		cfg_write(mta_pkg::REG_CHANNELS, 15'd7);
		cfg_write(mta_pkg::REG_CLAMP, 15'd0);
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'(mta_pkg::MODE_2D));
		send_item(mk(32767, -32768, 0, 2047, 15));
		send_item(mk(-16384, 0, 0, 0, 0));
		send_item(mk(16384, 1, 0, 1, 0));
		send_item(mk(-32768, -1, 2047, 2047, 14));
		send_item(mk(3, 2, 0, 5, 13));
		drain();

		// 1d with clamping, zero level count and zero channels
		cfg_write(mta_pkg::REG_WIDTH, 15'd100);
		cfg_write(mta_pkg::REG_LEVELS, 15'd0);
		cfg_write(mta_pkg::REG_CHANNELS, 15'd0);
		cfg_write(mta_pkg::REG_CLAMP, 15'd7);
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'(mta_pkg::MODE_1D));
		send_item(mk(-5, 7, 0, 9, 3));
		send_item(mk(200, 0, 0, 9, 0));
		drain();
		cfg_write(mta_pkg::REG_CHANNELS, 15'd1);
		send_item(mk(50, -3, 0, 2047, 0));
		send_item(mk(32767, 0, 0, 1, 0));
		drain();

		// 3d texture of the largest width and height, through the unused mode code
		cfg_write(mta_pkg::REG_WIDTH, mta_pkg::CDAT_W'(mta_pkg::MAX_DIM));
		cfg_write(mta_pkg::REG_HEIGHT, mta_pkg::CDAT_W'(mta_pkg::MAX_DIM));
		cfg_write(mta_pkg::REG_DEPTH, 15'd2048);
		cfg_write(mta_pkg::REG_LEVELS, 15'd15);
		cfg_write(mta_pkg::REG_CHANNELS, 15'd4);
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'(MODE_SPARE));
		send_item(mk(-1, -1, 2047, 2047, 14));
		send_item(mk(32767, 32767, 2047, 2047, 0));
		send_item(mk(0, 0, 0, 0, 7));
		drain();

		// 3d with coordinates outside the level, then 2d wrapping
		cfg_write(mta_pkg::REG_WIDTH, 15'd10);
		cfg_write(mta_pkg::REG_HEIGHT, 15'd10);
		cfg_write(mta_pkg::REG_DEPTH, 15'd10);
		cfg_write(mta_pkg::REG_LEVELS, 15'd5);
		cfg_write(mta_pkg::REG_CHANNELS, 15'd5);
		cfg_write(mta_pkg::REG_CLAMP, 15'd3);
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'(mta_pkg::MODE_3D));
		send_item(mk(-20, 30, 100, 4, 9));
		send_item(mk(12, -12, 11, 0, 1));
		drain();
		cfg_write(mta_pkg::REG_MODE, mta_pkg::CDAT_W'(mta_pkg::MODE_2D));
		cfg_write(mta_pkg::REG_CLAMP, 15'd0);
		send_item(mk(-10, 19, 0, 2, 0));
		send_item(mk(-11, 20, 0, 2, 0));
		send_item(mk(9, -1, 0, 2, 4));
		drain();

		for (int unsigned p = 0; p < PHASES; p++) begin
			steady = (p >= 5 && p <= 7);
			random_setting();
			for (int unsigned n = 0; n < PHASE_ITEMS; n++)
				send_item(random_req());
			drain();
		end
		steady = 1'b0;

		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.expected_addrs.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mta_pkg.sv
design/mta_cfg.sv
design/mta_remap.sv
design/mta_mac.sv
design/mip_texel_address_generator.sv
bench/tb.sv
